// ===== hw/rtl/lgs_pkg.sv =====
`timescale 1ns / 1ps
package lgs_pkg;

  // fixed field widths
  localparam int W_W   = 12;  // width_pixels
  localparam int RB_W  = 9;   // row_bytes
  localparam int H_W   = 13;  // height_rows
  localparam int ROW_W = 14;  // row counters, one above the largest height

  // queue between front and back
  localparam int QDEPTH = 4;

  // item opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_ROWB   = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_ALIVE  = 2'd3;

  // B3/S23 neighbor thresholds
  localparam logic [3:0] N_UNDER = 4'd2;
  localparam logic [3:0] N_OVER  = 4'd3;
  localparam logic [3:0] N_BIRTH = 4'd3;

  // one pipeline step as issued by the front
  typedef struct packed {
    logic [7:0] pix;        // newest byte written to the line store
    logic       bank;       // row parity
    logic       col0;       // first byte of a row
    logic       emit;       // this step yields a result
    logic       last;       // result closes the frame
    logic       top_ok;     // row above lies inside the image
    logic       bot_ok;     // row below lies inside the image
    logic       left_edge;  // result byte is the first of its row
    logic [7:0] in_img;     // cell inside the image, bit i is cell at bit i
    logic       right_in;   // first cell of the next byte inside the image
  } adv_t;

endpackage

// ===== hw/rtl/lgs_queue.sv =====
`timescale 1ns / 1ps
module lgs_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          full,
  output logic          empty
);
  import lgs_pkg::*;

  localparam int QA = $clog2(QDEPTH);

  logic [DW-1:0] slots [QDEPTH];
  logic [QA-1:0] wr_ptr;
  logic [QA-1:0] rd_ptr;
  logic [QA:0]   count;

  assign full     = count == (QA+1)'(QDEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/lgs_front.sv =====
`timescale 1ns / 1ps
module lgs_front #(
  parameter int MAX_ROW_BYTES = 256,
  parameter int CW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [lgs_pkg::W_W-1:0]  width_pixels,
  input  logic [lgs_pkg::RB_W-1:0] row_bytes,
  input  logic [lgs_pkg::H_W-1:0]  height_rows,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    op,
  input  logic [7:0]              pixel_byte,
  output logic                    push,
  output lgs_pkg::adv_t           push_desc,
  output logic [CW-1:0]           push_col,
  input  logic                    q_full
);
  import lgs_pkg::*;

  logic [CW-1:0]    in_col;
  logic [CW-1:0]    out_col;
  logic [ROW_W-1:0] in_row;
  logic [ROW_W-1:0] out_row;
  logic             draining;
  logic             drain_busy;

  logic [RB_W-1:0]  rb;
  logic [H_W-1:0]   h;
  logic [W_W-1:0]   lim;
  logic [W_W-1:0]   w;
  logic [15:0]      base;
  logic [8:0]       inside9;
  logic             filled;
  logic             last;
  logic             in_wrap;
  logic             out_wrap;
  logic             from_data;
  logic             adv_item;
  logic [ROW_W-1:0] in_row_next;

  // effective geometry
  always_comb begin
    if (row_bytes == '0) begin
      rb = RB_W'(1);
    end else if (13'(row_bytes) > 13'(MAX_ROW_BYTES)) begin
      rb = RB_W'(MAX_ROW_BYTES);
    end else begin
      rb = row_bytes;
    end
    h   = (height_rows == '0) ? H_W'(1) : height_rows;
    lim = {rb, 3'b000};
    w   = (width_pixels > lim) ? lim : width_pixels;
  end

  // which cells of the result byte lie inside the image
  always_comb begin
    base = 16'({out_col, 3'b000});
    for (int p = 0; p < 9; p++) begin
      inside9[p] = (base + 16'(p)) < 16'(w);
    end
  end

  assign filled   = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_col != '0);
  assign last     = (out_row + 1'b1 >= ROW_W'(h)) && (13'(out_col) + 13'd1 >= 13'(rb));
  assign in_wrap  = 13'(in_col) + 13'd1 >= 13'(rb);
  assign out_wrap = 13'(out_col) + 13'd1 >= 13'(rb);

  assign in_ready  = !drain_busy && !q_full;
  assign from_data = !drain_busy && op == OP_DATA;
  assign adv_item  = (op == OP_DATA) ? !draining : draining;
  assign push      = drain_busy ? !q_full : (in_valid && in_ready && adv_item);

  assign in_row_next = in_wrap ? in_row + 1'b1 : in_row;

  always_comb begin
    push_desc.pix       = from_data ? pixel_byte : 8'h00;
    push_desc.bank      = in_row[0];
    push_desc.col0      = in_col == '0;
    push_desc.emit      = filled;
    push_desc.last      = last;
    push_desc.top_ok    = out_row != '0;
    push_desc.bot_ok    = !(out_row + 1'b1 >= ROW_W'(h));
    push_desc.left_edge = out_col == '0;
    for (int i = 0; i < 8; i++) begin
      push_desc.in_img[i] = inside9[7-i];
    end
    push_desc.right_in  = inside9[8];
    push_col            = in_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_row     <= '0;
      out_col    <= '0;
      out_row    <= '0;
      draining   <= 1'b0;
      drain_busy <= 1'b0;
    end else if (push) begin
      if (filled && last) begin
        in_col     <= '0;
        in_row     <= '0;
        out_col    <= '0;
        out_row    <= '0;
        draining   <= 1'b0;
        drain_busy <= 1'b0;
      end else begin
        in_col <= in_wrap ? '0 : in_col + 1'b1;
        in_row <= in_row_next;
        if (filled) begin
          out_col <= out_wrap ? '0 : out_col + 1'b1;
          out_row <= out_wrap ? out_row + 1'b1 : out_row;
        end
        if (from_data) begin
          draining <= in_row_next >= ROW_W'(h);
        end
        drain_busy <= !from_data && !filled;
      end
    end
  end

endmodule

// ===== hw/rtl/lgs_back.sv =====
`timescale 1ns / 1ps
module lgs_back #(
  parameter int MAX_ROW_BYTES = 256,
  parameter int CW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          alive_bit,
  input  logic          q_empty,
  output logic          pop,
  input  lgs_pkg::adv_t pop_desc,
  input  logic [CW-1:0] pop_col,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    next_byte,
  output logic          frame_end
);
  import lgs_pkg::*;

  logic [7:0] bank0 [MAX_ROW_BYTES];
  logic [7:0] bank1 [MAX_ROW_BYTES];
  logic [7:0] rd0;
  logic [7:0] rd1;

  logic        go;
  logic        b_valid;
  adv_t        b;
  logic [7:0]  older;
  logic [7:0]  prev;
  logic [8:0][7:0] win;
  logic [8:0][7:0] ws;
  logic [9:0]  ext [3];
  logic [7:0]  lb;
  logic [7:0]  cb;
  logic [7:0]  rbt;
  logic [3:0]  n;
  logic        self_live;
  logic        use_row;
  logic        lv;
  logic        rv;
  logic        flip;
  logic [7:0]  res;

  assign go  = !out_valid || out_ready;
  assign pop = go && !q_empty;

  // line store, one bank per row parity
  always_ff @(posedge clk) begin
    if (pop) begin
      rd0 <= bank0[pop_col];
      if (!pop_desc.bank) bank0[pop_col] <= pop_desc.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd1 <= bank1[pop_col];
      if (pop_desc.bank) bank1[pop_col] <= pop_desc.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b <= pop_desc;
    end
  end

  assign older = b.bank ? rd1 : rd0;
  assign prev  = b.bank ? rd0 : rd1;

  // window after shifting in the new column
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ws[k] = win[k+3];
    end
    ws[6] = b.col0 ? 8'h00 : older;
    ws[7] = b.col0 ? 8'h00 : prev;
    ws[8] = b.col0 ? 8'h00 : b.pix;
  end

  // B3/S23 on the center byte
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lb  = alive_bit ? ws[r]   : ~ws[r];
      cb  = alive_bit ? ws[3+r] : ~ws[3+r];
      rbt = alive_bit ? ws[6+r] : ~ws[6+r];
      ext[r] = {lb[0], cb, rbt[7]};
    end
    for (int i = 0; i < 8; i++) begin
      n = 4'd0;
      for (int r = 0; r < 3; r++) begin
        use_row = (r == 0) ? b.top_ok : ((r == 2) ? b.bot_ok : 1'b1);
        lv = (i < 7) || !b.left_edge;
        rv = (i > 0) ? b.in_img[(i > 0) ? i-1 : 0] : b.right_in;
        if (use_row) begin
          if (lv) n = n + 4'(ext[r][i+2]);
          if (r != 1) n = n + 4'(ext[r][i+1]);
          if (rv) n = n + 4'(ext[r][i]);
        end
      end
      self_live = ext[1][i+1];
      flip = b.in_img[i] &&
             (self_live ? (n < N_UNDER || n > N_OVER) : (n == N_BIRTH));
      res[i] = ws[4][i] ^ flip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
      win       <= '0;
    end else if (go) begin
      b_valid   <= !q_empty;
      out_valid <= b_valid && b.emit;
      if (b_valid) begin
        if (b.emit && b.last) begin
          win <= '0;
        end else if (b.col0) begin
          win <= {b.pix, prev, older, 48'h0};
        end else begin
          win <= ws;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && b_valid && b.emit) begin
      next_byte <= res;
      frame_end <= b.last;
    end
  end

endmodule

// ===== hw/rtl/life_generation_stencil_top.sv =====
`timescale 1ns / 1ps
// Game of Life stepper (B3/S23) over a packed 1-bit image streamed in raster order, one
// byte of eight cells per item, leftmost cell in bit 7. Set width_pixels, row_bytes,
// height_rows and alive_bit over the register port while the block is idle, send the
// frame as data items (op = 0), then send drain items (op = 1) until the result with
// frame_end arrives. Results lag the input by row_bytes + 1 items; data items sent while
// draining are dropped, drain items sent while not draining are dropped. The border does
// not wrap and bits past width_pixels pass through. Data items and drain items are taken
// one per cycle while the step queue is not full; a drain item that yields no result, as the
// first on a one-row frame does, holds the input while the front issues a further step. The
// rate is set by the line store, two row banks each with one read and one write per cycle.
// Each step passes through the queue, the line store read and the rule stage in turn.
module life_generation_stencil_top #(
  parameter int MAX_ROW_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  pixel_byte,
  // result item channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  next_byte,
  output logic        frame_end,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lgs_pkg::*;

  // line store column address width
  localparam int CW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int QW = $bits(adv_t) + CW;

  // configuration registers
  logic [W_W-1:0]  width_pixels;
  logic [RB_W-1:0] row_bytes;
  logic [H_W-1:0]  height_rows;
  logic            alive_bit;

  // front to queue to back
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  adv_t          push_desc;
  logic [CW-1:0] push_col;
  adv_t          pop_desc;
  logic [CW-1:0] pop_col;
  logic [QW-1:0] pop_data;

  assign pready = 1'b1;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= W_W'(32);
      row_bytes    <= RB_W'(4);
      height_rows  <= H_W'(32);
      alive_bit    <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_pixels <= pwdata[W_W-1:0];
        REG_ROWB:   row_bytes    <= pwdata[RB_W-1:0];
        REG_HEIGHT: height_rows  <= pwdata[H_W-1:0];
        REG_ALIVE:  alive_bit    <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_pixels);
      REG_ROWB:   prdata = 32'(row_bytes);
      REG_HEIGHT: prdata = 32'(height_rows);
      REG_ALIVE:  prdata = 32'(alive_bit);
      default:    prdata = 32'h0;
    endcase
  end

  // front: counters, drain control, masks
  lgs_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .width_pixels(width_pixels),
    .row_bytes(row_bytes),
    .height_rows(height_rows),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .pixel_byte(pixel_byte),
    .push(q_push),
    .push_desc(push_desc),
    .push_col(push_col),
    .q_full(q_full)
  );

  // step queue, lets the back stall without holding the input until the queue is full
  lgs_queue #(
    .DW(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data({push_desc, push_col}),
    .pop(q_pop),
    .pop_data(pop_data),
    .full(q_full),
    .empty(q_empty)
  );

  assign pop_desc = pop_data[QW-1:CW];
  assign pop_col  = pop_data[CW-1:0];

  // back: line store, window, rule and result register
  lgs_back #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .alive_bit(alive_bit),
    .q_empty(q_empty),
    .pop(q_pop),
    .pop_desc(pop_desc),
    .pop_col(pop_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_byte(next_byte),
    .frame_end(frame_end)
  );

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("step queue overflow");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("step queue underflow");

  // a held result stalls the whole back end
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("back end moved while result held");
`endif

endmodule
